[rtl/hkfe_pkg.sv]
// Shared types, constants and code tables of the half-width kana converter.
`timescale 1ns / 1ps
`default_nettype none

package hkfe_pkg;

	localparam logic [7:0] KANA_PREFIX = 8'h8e;
	localparam logic [7:0] SS3_LEAD    = 8'h8f;
	localparam logic [7:0] KANA_FIRST  = 8'ha1;
	localparam logic [7:0] KANA_LAST   = 8'hdf;
	localparam logic [7:0] VOICED_MARK = 8'hde;
	localparam logic [7:0] SEMI_MARK   = 8'hdf;
	localparam logic [7:0] PRINT_FIRST = 8'h20;
	localparam logic [7:0] PRINT_LAST  = 8'h7e;
	localparam logic [7:0] MB_FIRST    = 8'h80;
	localparam logic [15:0] TOFU_CODE  = 16'ha2a2;

	localparam int KANA_DEPTH = 63;
	localparam int WIDE_DEPTH = 95;
	localparam int MAX_BYTES  = 4;

	// Register indexes of the configuration port
	localparam logic CFG_MERGE_MARKS = 1'b0;
	localparam logic CFG_WIDEN_ASCII = 1'b1;

	localparam logic [15:0] KANA_ROM [KANA_DEPTH] = '{
		16'ha1a3, 16'ha1d6, 16'ha1d7, 16'ha1a2, 16'ha1a6, 16'ha4f2, 16'ha4a1,
		16'ha4a3, 16'ha4a5, 16'ha4a7, 16'ha4a9, 16'ha4e3, 16'ha4e5, 16'ha4e7, 16'ha4c3,
		16'ha1bc, 16'ha4a2, 16'ha4a4, 16'ha4a6, 16'ha4a8, 16'ha4aa, 16'ha4ab, 16'ha4ad,
		16'ha4af, 16'ha4b1, 16'ha4b3, 16'ha4b5, 16'ha4b7, 16'ha4b9, 16'ha4bb, 16'ha4bd,
		16'ha4bf, 16'ha4c1, 16'ha4c4, 16'ha4c6, 16'ha4c8, 16'ha4ca, 16'ha4cb, 16'ha4cc,
		16'ha4cd, 16'ha4ce, 16'ha4cf, 16'ha4d2, 16'ha4d5, 16'ha4d8, 16'ha4db, 16'ha4de,
		16'ha4df, 16'ha4e0, 16'ha4e1, 16'ha4e2, 16'ha4e4, 16'ha4e6, 16'ha4e8, 16'ha4e9,
		16'ha4ea, 16'ha4eb, 16'ha4ec, 16'ha4ed, 16'ha4ef, 16'ha4f3, 16'ha1ab, 16'ha1ac
	};

	localparam logic [15:0] WIDE_ROM [WIDE_DEPTH] = '{
		16'ha1a1, 16'ha1aa, 16'ha1c9, 16'ha1f4, 16'ha1f0, 16'ha1f3, 16'ha1f5, 16'ha1c7,
		16'ha1ca, 16'ha1cb, 16'ha1f6, 16'ha1dc, 16'ha1a4, 16'ha1dd, 16'ha1a5, 16'ha1bf,
		16'ha3b0, 16'ha3b1, 16'ha3b2, 16'ha3b3, 16'ha3b4, 16'ha3b5, 16'ha3b6, 16'ha3b7,
		16'ha3b8, 16'ha3b9, 16'ha1a7, 16'ha1a8, 16'ha1e3, 16'ha1e1, 16'ha1e4, 16'ha1a9,
		16'ha1f7, 16'ha3c1, 16'ha3c2, 16'ha3c3, 16'ha3c4, 16'ha3c5, 16'ha3c6, 16'ha3c7,
		16'ha3c8, 16'ha3c9, 16'ha3ca, 16'ha3cb, 16'ha3cc, 16'ha3cd, 16'ha3ce, 16'ha3cf,
		16'ha3d0, 16'ha3d1, 16'ha3d2, 16'ha3d3, 16'ha3d4, 16'ha3d5, 16'ha3d6, 16'ha3d7,
		16'ha3d8, 16'ha3d9, 16'ha3da, 16'ha1ce, 16'ha1c0, 16'ha1cf, 16'ha1b0, 16'ha1b2,
		16'ha1c6, 16'ha3e1, 16'ha3e2, 16'ha3e3, 16'ha3e4, 16'ha3e5, 16'ha3e6, 16'ha3e7,
		16'ha3e8, 16'ha3e9, 16'ha3ea, 16'ha3eb, 16'ha3ec, 16'ha3ed, 16'ha3ee, 16'ha3ef,
		16'ha3f0, 16'ha3f1, 16'ha3f2, 16'ha3f3, 16'ha3f4, 16'ha3f5, 16'ha3f6, 16'ha3f7,
		16'ha3f8, 16'ha3f9, 16'ha3fa, 16'ha1d0, 16'ha1c3, 16'ha1d1, 16'ha1c1
	};

	typedef struct packed {
		logic merge_marks;
		logic widen_ascii;
	} hkfe_cfg_t;

	// All bytes one input word produces, first byte in slot 0
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                count;
		logic                      eot;
	} hkfe_res_t;

	// Kana index 63 folds back to entry 0
	function automatic logic [15:0] kana_code(input logic [5:0] idx);
		logic [15:0] code;
		if (idx == 6'(KANA_DEPTH)) code = KANA_ROM[0];
		else code = KANA_ROM[idx];
		return code;
	endfunction

	function automatic logic takes_voiced(input logic [5:0] idx);
		return (idx >= 6'h15 && idx <= 6'h23) || (idx >= 6'h29 && idx <= 6'h2d);
	endfunction

	function automatic logic takes_semi(input logic [5:0] idx);
		return idx >= 6'h29 && idx <= 6'h2d;
	endfunction

endpackage

`default_nettype wire

[rtl/hkfe_if.sv]
// Valid/ready channel interfaces for input text words and output bytes.
`timescale 1ns / 1ps
`default_nettype none

interface hkfe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface hkfe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       text_done;

	modport source (output valid, output out_byte, output run_last, output text_done,
		input ready);
	modport sink (input valid, input out_byte, input run_last, input text_done,
		output ready);
endinterface

`default_nettype wire

[rtl/halfwidth_kana_to_fullwidth_euc.sv]
// Top level of the half-width kana to full-width EUC-JP converter.
// Usage:
//  - text channel: one EUC-JP byte per word, with end_of_text on the last
//    byte of a text. A word is taken when valid and ready are both high.
//  - result channel: zero to four converted bytes per input word, one per
//    word; run_last marks the last byte caused by an input word and
//    text_done the last byte of the whole text.
//  - cfg_we/cfg_index/cfg_wdata: index 0 merge_marks (reset 1), index 1
//    widen_ascii (reset 0). Write only while the converter is idle.
//  - A word passes through the input register, then the result register,
//    before the receiver can take its first byte.
//  - Throughput: one input word per cycle while each word yields at most one
//    byte and the receiver is ready; otherwise the result register holds
//    the input back until the last byte of the word before it is taken.
//  - With merge_marks set, a kana that can take a mark is held without output
//    until the next character or the end of the text shows whether a mark follows.
//  - Reset clears the decode state and empties both registers; the configuration
//    returns to its reset values.
//  - When the receiver stalls, the result register holds its byte and the
//    input register fills; ready on the text channel then drops.
`timescale 1ns / 1ps
`default_nettype none

module halfwidth_kana_to_fullwidth_euc (
	input  wire        clk,
	input  wire        arst_n,
	hkfe_in_if.sink    text,
	hkfe_out_if.source result,
	input  wire        cfg_we,
	input  wire        cfg_index,
	input  wire        cfg_wdata
);
	import hkfe_pkg::*;

	hkfe_cfg_t cfg_q;
	hkfe_res_t res;
	logic      res_valid;
	logic      res_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.merge_marks <= 1'b1;
			cfg_q.widen_ascii <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MERGE_MARKS: cfg_q.merge_marks <= cfg_wdata;
				CFG_WIDEN_ASCII: cfg_q.widen_ascii <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Decode one word per pass and advance the state
	hkfe_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Hold the produced bytes and drain them one per cycle while the receiver is ready
	hkfe_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.result    (result)
	);

endmodule

`default_nettype wire

[rtl/hkfe_conv.sv]
// Input register, decode state and single-pass conversion of one text word.
`timescale 1ns / 1ps
`default_nettype none

module hkfe_conv (
	input  wire                 clk,
	input  wire                 arst_n,
	hkfe_in_if.sink             text,
	input  hkfe_pkg::hkfe_cfg_t cfg,
	output logic                res_valid,
	input  wire                 res_ready,
	output hkfe_pkg::hkfe_res_t res
);
	import hkfe_pkg::*;

	typedef enum logic [1:0] {
		PH_LEAD = 2'd0,
		PH_KANA = 2'd1,
		PH_LAST = 2'd2,
		PH_MID  = 2'd3
	} phase_t;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	phase_t     phase_q, phase_d;
	logic [5:0] held_q, held_d;
	logic       held_valid_q, held_valid_d;
	logic       mark_seen_q, mark_seen_d;

	logic        pre_flush, post_flush;
	logic        main_byte_en, main_code_en;
	logic [7:0]  main_byte;
	logic [15:0] main_code;
	logic [15:0] pre_code, post_code;
	logic [7:0]  b;
	logic [5:0]  kidx;
	logic [6:0]  widx;
	logic        advance;

	assign b    = byte_s1;
	assign kidx = 6'(b - KANA_FIRST);
	assign widx = 7'(b - PRINT_FIRST);

	assign advance    = valid_s1 && res_ready;
	assign text.ready = !valid_s1 || res_ready;
	assign res_valid  = valid_s1;

	always_comb begin
		phase_d      = phase_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		mark_seen_d  = mark_seen_q;
		pre_flush    = 1'b0;
		main_byte_en = 1'b0;
		main_code_en = 1'b0;
		main_byte    = b;
		main_code    = TOFU_CODE;
		pre_code     = kana_code(held_q);

		case (phase_q)
			PH_LEAD: begin
				if (held_valid_q && !mark_seen_q && b == KANA_PREFIX) begin
					mark_seen_d = 1'b1;
					phase_d     = PH_KANA;
				end else begin
					pre_flush    = held_valid_q;
					held_valid_d = 1'b0;
					held_d       = '0;
					mark_seen_d  = 1'b0;
					if (b < MB_FIRST) begin
						phase_d = PH_LEAD;
						if (cfg.widen_ascii && b >= PRINT_FIRST && b <= PRINT_LAST) begin
							main_code_en = 1'b1;
							main_code    = WIDE_ROM[widx];
						end else begin
							main_byte_en = 1'b1;
						end
					end else if (b == KANA_PREFIX) begin
						phase_d = PH_KANA;
					end else if (b == SS3_LEAD) begin
						main_byte_en = 1'b1;
						phase_d      = PH_MID;
					end else begin
						main_byte_en = 1'b1;
						phase_d      = PH_LAST;
					end
				end
			end
			PH_KANA: begin
				phase_d = PH_LEAD;
				if (held_valid_q && mark_seen_q && cfg.merge_marks &&
						b == VOICED_MARK && takes_voiced(held_q)) begin
					main_code_en = 1'b1;
					main_code    = kana_code(held_q) + 16'd1;
					held_valid_d = 1'b0;
					held_d       = '0;
					mark_seen_d  = 1'b0;
				end else if (held_valid_q && mark_seen_q && cfg.merge_marks &&
						b == SEMI_MARK && takes_semi(held_q)) begin
					main_code_en = 1'b1;
					main_code    = kana_code(held_q) + 16'd2;
					held_valid_d = 1'b0;
					held_d       = '0;
					mark_seen_d  = 1'b0;
				end else begin
					pre_flush    = held_valid_q;
					held_valid_d = 1'b0;
					held_d       = '0;
					mark_seen_d  = 1'b0;
					if (b < KANA_FIRST || b > KANA_LAST) begin
						main_code_en = 1'b1;
						main_code    = TOFU_CODE;
					end else if (cfg.merge_marks && takes_voiced(kidx)) begin
						held_d       = kidx;
						held_valid_d = 1'b1;
					end else begin
						main_code_en = 1'b1;
						main_code    = kana_code(kidx);
					end
				end
			end
			PH_MID: begin
				main_byte_en = 1'b1;
				phase_d      = PH_LAST;
			end
			default: begin
				main_byte_en = 1'b1;
				phase_d      = PH_LEAD;
			end
		endcase

		// End of text: flush what is held, drop a dangling prefix
		post_flush = eot_s1 && held_valid_d;
		post_code  = kana_code(held_d);
		if (eot_s1) begin
			held_valid_d = 1'b0;
			held_d       = '0;
			mark_seen_d  = 1'b0;
			phase_d      = PH_LEAD;
		end
	end

	// Pack the bytes in emission order
	always_comb begin
		logic [2:0] n;
		n         = '0;
		res.bytes = '0;
		res.eot   = eot_s1;
		if (pre_flush) begin
			res.bytes[n[1:0]] = pre_code[15:8];
			n = n + 3'd1;
			res.bytes[n[1:0]] = pre_code[7:0];
			n = n + 3'd1;
		end
		if (main_byte_en) begin
			res.bytes[n[1:0]] = main_byte;
			n = n + 3'd1;
		end
		if (main_code_en) begin
			res.bytes[n[1:0]] = main_code[15:8];
			n = n + 3'd1;
			res.bytes[n[1:0]] = main_code[7:0];
			n = n + 3'd1;
		end
		if (post_flush) begin
			res.bytes[n[1:0]] = post_code[15:8];
			n = n + 3'd1;
			res.bytes[n[1:0]] = post_code[7:0];
			n = n + 3'd1;
		end
		res.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			phase_q      <= PH_LEAD;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			mark_seen_q  <= 1'b0;
		end else begin
			if (text.valid && text.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				phase_q      <= phase_d;
				held_q       <= held_d;
				held_valid_q <= held_valid_d;
				mark_seen_q  <= mark_seen_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.in_byte;
			eot_s1  <= text.end_of_text;
		end
	end

endmodule

`default_nettype wire

[rtl/hkfe_obuf.sv]
// Result register that hands out the converted bytes one per cycle while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none

module hkfe_obuf (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 res_valid,
	output logic                res_ready,
	input  hkfe_pkg::hkfe_res_t res,
	hkfe_out_if.source          result
);
	import hkfe_pkg::*;

	hkfe_res_t  buf_q;
	logic [1:0] idx_q;
	logic       valid_q;
	logic       last_byte;

	assign last_byte        = {1'b0, idx_q} == (buf_q.count - 3'd1);
	assign result.valid     = valid_q;
	assign result.out_byte  = buf_q.bytes[idx_q];
	assign result.run_last  = last_byte;
	assign result.text_done = last_byte && buf_q.eot;
	assign res_ready        = !valid_q || (result.ready && last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (res_valid && res_ready) begin
				// a word that yields no byte leaves the register empty
				valid_q <= res.count != 3'd0;
				idx_q   <= '0;
			end else if (result.valid && result.ready) begin
				if (last_byte) begin
					valid_q <= 1'b0;
				end
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			buf_q <= res;
		end
	end

endmodule

`default_nettype wire
